// ----- hdl/mfh_pkg.sv -----
// Shared types, constants and register codes of the message fragmenter.
// Used by every module of the block; depends on nothing.
package mfh_pkg;

  localparam int MAX_FRAGMENT_SIZE = 512;
  localparam int PAY_W = 10;
  localparam int LEN_W = 32;
  localparam int BYTE_W = 8;

  localparam logic [PAY_W-1:0] MIN_PAYLOAD = PAY_W'(6);
  localparam logic [PAY_W-1:0] MAX_PAYLOAD = PAY_W'(MAX_FRAGMENT_SIZE);
  localparam logic [PAY_W-1:0] FIRST_HDR_LEN = PAY_W'(5);
  localparam logic [PAY_W-1:0] CONT_HDR_LEN = PAY_W'(1);

  // Queue between the classifier and the serializer.
  localparam int QDEPTH = 4;
  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  // Byte position inside one queued request (up to five header bytes + data).
  localparam int POS_W = 3;
  localparam logic [POS_W-1:0] POS_FIRST_LAST = POS_W'(5);
  localparam logic [POS_W-1:0] POS_CONT_LAST = POS_W'(1);
  localparam logic [POS_W-1:0] POS_NONE_LAST = POS_W'(0);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAYLOAD_SIZE = 3'd0,
    REG_CODE_SINGLE  = 3'd1,
    REG_CODE_FIRST   = 3'd2,
    REG_CODE_MIDDLE  = 3'd3,
    REG_CODE_END     = 3'd4
  } cfg_reg_t;

  localparam logic [PAY_W-1:0] RST_PAYLOAD_SIZE = PAY_W'(20);
  localparam logic [BYTE_W-1:0] RST_CODE_SINGLE = 8'd0;
  localparam logic [BYTE_W-1:0] RST_CODE_FIRST = 8'd1;
  localparam logic [BYTE_W-1:0] RST_CODE_MIDDLE = 8'd2;
  localparam logic [BYTE_W-1:0] RST_CODE_END = 8'd3;

  typedef enum logic [1:0] {
    HDR_NONE  = 2'd0,
    HDR_FIRST = 2'd1,
    HDR_CONT  = 2'd2
  } hdr_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  message_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              fragment_end;
    logic              message_end;
  } out_item_t;

  typedef struct packed {
    logic [PAY_W-1:0]  payload_size;
    logic [BYTE_W-1:0] code_single;
    logic [BYTE_W-1:0] code_first;
    logic [BYTE_W-1:0] code_middle;
    logic [BYTE_W-1:0] code_end;
  } cfg_t;

  // One classified request: header kind, its bytes and the data byte.
  typedef struct packed {
    hdr_kind_t         kind;
    logic [BYTE_W-1:0] code;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data_byte;
    logic              fragment_end;
    logic              message_end;
  } frag_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ----- hdl/message_fragmenter_with_headers.sv -----
// Message fragmenter: cuts a byte stream into fragments of payload_size bytes,
// header included. The first fragment opens with a control byte and the
// 4-byte big-endian message length; each later fragment opens with one
// control byte. One message byte enters per cycle unless in_stall holds it;
// the output delivers one byte per cycle unless out_stall holds it. An input
// byte yields one, two or six output bytes (plain data, continuation header,
// first header). The byte serializer sets the rate; a four-entry request
// queue lets input run ahead while headers go out, and in_stall rises only
// when that queue is full. A request's first output byte goes through the
// queue and then the output register. The user must write configuration
// through the cfg port only while no message is in flight; the block does
// not enforce it. Depends on mfh_pkg, mfh_front, mfh_queue and mfh_back.
module message_fragmenter_with_headers (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mfh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mfh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  input  mfh_pkg::in_item_t                 in_data,
  output logic                              in_stall,
  output logic                              out_valid,
  output mfh_pkg::out_item_t                out_data,
  input  logic                              out_stall
);

  mfh_pkg::cfg_t      cfg_r, cfg_nxt;
  mfh_pkg::q_status_t q_status;
  mfh_pkg::frag_req_t q_req;
  mfh_pkg::frag_req_t q_head;
  logic               q_push;
  logic               q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mfh_pkg::REG_PAYLOAD_SIZE: cfg_nxt.payload_size = cfg_wdata;
        mfh_pkg::REG_CODE_SINGLE:  cfg_nxt.code_single = cfg_wdata[7:0];
        mfh_pkg::REG_CODE_FIRST:   cfg_nxt.code_first = cfg_wdata[7:0];
        mfh_pkg::REG_CODE_MIDDLE:  cfg_nxt.code_middle = cfg_wdata[7:0];
        mfh_pkg::REG_CODE_END:     cfg_nxt.code_end = cfg_wdata[7:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.payload_size <= mfh_pkg::RST_PAYLOAD_SIZE;
      cfg_r.code_single <= mfh_pkg::RST_CODE_SINGLE;
      cfg_r.code_first <= mfh_pkg::RST_CODE_FIRST;
      cfg_r.code_middle <= mfh_pkg::RST_CODE_MIDDLE;
      cfg_r.code_end <= mfh_pkg::RST_CODE_END;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mfh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_status (q_status),
    .q_push   (q_push),
    .q_req    (q_req)
  );

  mfh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (q_req),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  mfh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

`ifndef SYNTHESIS
  // The last byte of a message always closes its fragment.
  a_mend_implies_fend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.message_end |-> out_data.fragment_end)
    else $error("message end without fragment end");

  // The serializer never retires a request the queue does not hold.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("queue pop while empty");

  // A request is only queued when there is room for it.
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full && in_valid)
    else $error("queue push while full");
`endif

endmodule

// ----- hdl/mfh_front.sv -----
// Classifier: accepts message bytes, tracks fragment and message position and
// decides which header opens each byte. Depends on mfh_pkg.
module mfh_front (
  input  logic                clk,
  input  logic                rst_n,
  input  mfh_pkg::cfg_t       cfg,
  input  logic                in_valid,
  input  mfh_pkg::in_item_t   in_data,
  output logic                in_stall,
  input  mfh_pkg::q_status_t  q_status,
  output logic                q_push,
  output mfh_pkg::frag_req_t  q_req
);

  logic [mfh_pkg::LEN_W-1:0] remaining_r, remaining_nxt;
  logic [mfh_pkg::PAY_W-1:0] fill_r, fill_nxt;
  logic                      open_r, open_nxt;

  logic                      accept;
  logic                      idle;
  logic                      drop;
  logic [mfh_pkg::PAY_W-1:0] pay;
  logic [mfh_pkg::PAY_W-1:0] fill_base;
  logic [mfh_pkg::PAY_W-1:0] fill_inc;
  logic [mfh_pkg::LEN_W-1:0] rem_cur;
  logic                      mend;
  logic                      fend;

  // Payload size is used saturated to the legal fragment range.
  always_comb begin
    if (cfg.payload_size < mfh_pkg::MIN_PAYLOAD) begin
      pay = mfh_pkg::MIN_PAYLOAD;
    end else if (cfg.payload_size > mfh_pkg::MAX_PAYLOAD) begin
      pay = mfh_pkg::MAX_PAYLOAD;
    end else begin
      pay = cfg.payload_size;
    end
  end

  assign in_stall = q_status.full;
  assign accept = in_valid && !q_status.full;
  assign idle = (remaining_r == '0);
  assign drop = idle && (in_data.message_length == '0);
  assign q_push = accept && !drop;

  always_comb begin
    q_req.kind = mfh_pkg::HDR_NONE;
    q_req.code = cfg.code_middle;
    fill_base = fill_r;
    rem_cur = remaining_r;
    if (idle) begin
      q_req.kind = mfh_pkg::HDR_FIRST;
      rem_cur = in_data.message_length;
      fill_base = mfh_pkg::FIRST_HDR_LEN;
      if (in_data.message_length <=
          mfh_pkg::LEN_W'(pay - mfh_pkg::FIRST_HDR_LEN)) begin
        q_req.code = cfg.code_single;
      end else begin
        q_req.code = cfg.code_first;
      end
    end else if (!open_r) begin
      q_req.kind = mfh_pkg::HDR_CONT;
      fill_base = mfh_pkg::CONT_HDR_LEN;
      if (remaining_r <= mfh_pkg::LEN_W'(pay - mfh_pkg::CONT_HDR_LEN)) begin
        q_req.code = cfg.code_end;
      end else begin
        q_req.code = cfg.code_middle;
      end
    end
    fill_inc = fill_base + mfh_pkg::PAY_W'(1);
    mend = (rem_cur == mfh_pkg::LEN_W'(1));
    fend = mend || (fill_inc >= pay);
    q_req.length = in_data.message_length;
    q_req.data_byte = in_data.data_byte;
    q_req.fragment_end = fend;
    q_req.message_end = mend;
  end

  always_comb begin
    remaining_nxt = remaining_r;
    fill_nxt = fill_r;
    open_nxt = open_r;
    if (q_push) begin
      remaining_nxt = rem_cur - mfh_pkg::LEN_W'(1);
      if (fend) begin
        fill_nxt = '0;
        open_nxt = 1'b0;
      end else begin
        fill_nxt = fill_inc;
        open_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      fill_r <= '0;
      open_r <= 1'b0;
    end else begin
      remaining_r <= remaining_nxt;
      fill_r <= fill_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

// ----- hdl/mfh_queue.sv -----
// Short request queue between the classifier and the serializer.
// Depends on mfh_pkg for the request type and depth.
module mfh_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mfh_pkg::frag_req_t  push_req,
  input  logic                pop,
  output mfh_pkg::frag_req_t  head,
  output mfh_pkg::q_status_t  status
);

  mfh_pkg::frag_req_t        mem_r [mfh_pkg::QDEPTH];
  logic [mfh_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mfh_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mfh_pkg::CNT_W-1:0] count_r, count_nxt;

  assign status.empty = (count_r == '0);
  assign status.full = (count_r == mfh_pkg::CNT_W'(mfh_pkg::QDEPTH));
  assign head = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mfh_pkg::PTR_W'(mfh_pkg::QDEPTH - 1)) ?
                   '0 : wr_ptr_r + mfh_pkg::PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mfh_pkg::PTR_W'(mfh_pkg::QDEPTH - 1)) ?
                   '0 : rd_ptr_r + mfh_pkg::PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + mfh_pkg::CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - mfh_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hdl/mfh_back.sv -----
// Serializer: walks the header and data bytes of the queued request at the
// head and drives the registered output channel. Depends on mfh_pkg.
module mfh_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mfh_pkg::frag_req_t  head,
  input  mfh_pkg::q_status_t  q_status,
  output logic                q_pop,
  output logic                out_valid,
  output mfh_pkg::out_item_t  out_data,
  input  logic                out_stall
);

  logic [mfh_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                      out_valid_r, out_valid_nxt;
  mfh_pkg::out_item_t        out_data_r;

  logic                      advance;
  logic [mfh_pkg::POS_W-1:0] last_pos;
  mfh_pkg::out_item_t        cur;

  assign advance = !q_status.empty && (!out_valid_r || !out_stall);
  assign q_pop = advance && (pos_r == last_pos);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    last_pos = mfh_pkg::POS_NONE_LAST;
    cur.out_byte = head.data_byte;
    cur.fragment_end = 1'b0;
    cur.message_end = 1'b0;
    unique case (head.kind)
      mfh_pkg::HDR_FIRST: begin
        last_pos = mfh_pkg::POS_FIRST_LAST;
        unique case (pos_r)
          3'd0: cur.out_byte = head.code;
          3'd1: cur.out_byte = head.length[31:24];
          3'd2: cur.out_byte = head.length[23:16];
          3'd3: cur.out_byte = head.length[15:8];
          3'd4: cur.out_byte = head.length[7:0];
          default: cur.out_byte = head.data_byte;
        endcase
      end
      mfh_pkg::HDR_CONT: begin
        last_pos = mfh_pkg::POS_CONT_LAST;
        if (pos_r == '0) begin
          cur.out_byte = head.code;
        end
      end
      default: begin
        last_pos = mfh_pkg::POS_NONE_LAST;
      end
    endcase
    // Only the data byte, the last of a request, carries the end flags.
    if (pos_r == last_pos) begin
      cur.out_byte = head.data_byte;
      cur.fragment_end = head.fragment_end;
      cur.message_end = head.message_end;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      pos_nxt = q_pop ? '0 : pos_r + mfh_pkg::POS_W'(1);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
